@@ rtl/tpc_pkg.sv @@
`default_nettype none

package tpc_pkg;

   localparam int unsigned CSR_INDEX_W = 8;
   localparam int unsigned CSR_DATA_W  = 16;

   localparam int unsigned TPS_W       = 10;
   localparam int unsigned FPT_W       = 16;
   localparam int unsigned SEL_W       = 4;
   localparam int unsigned MAG_W       = 4;
   localparam int unsigned DUR_W       = 8;
   localparam int unsigned PCT_W       = 7;

   localparam logic [CSR_INDEX_W-1:0] REG_TICKS_PER_SECOND = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_FUEL_PER_TICK    = CSR_INDEX_W'(1);

   localparam logic [TPS_W-1:0] TPS_RESET      = TPS_W'(100);
   localparam logic [FPT_W-1:0] FPT_RESET      = FPT_W'(21);
   localparam logic [PCT_W-1:0] FUEL_FULL_PCT  = PCT_W'(100);
   localparam logic [DUR_W-1:0] ELAPSED_MAX    = '1;

   typedef struct packed {
      logic                   command_valid;
      logic [15:0]            command_word;
   } req_payload_type;

   typedef struct packed {
      logic                   drive_down;
      logic                   drive_up;
      logic                   drive_right;
      logic                   drive_left;
      logic                   impulse_on;
      logic                   command_active;
      logic [PCT_W-1:0]       fuel_percent;
   } rsp_payload_type;

   typedef struct packed {
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  data;
   } csr_payload_type;

endpackage

`default_nettype wire

@@ rtl/tpc_stream_if.sv @@
`default_nettype none

interface tpc_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ rtl/thruster_pulse_controller.sv @@
// Thruster pulse controller: one request per task tick, one response per request, in order.
// A request may carry a new command (select, magnitude, duration) that restarts the pulse
// timing. A request is taken every cycle when the response side keeps up; a response is
// offered from the result register after its request has passed the input register (one input
// register, one result register), and the whole tick update sits between those two registers.
// Config (ticks_per_second at index 0, fuel_per_tick at index 1, other indexes ignored) is
// taken every cycle and must only be written while no request is in flight.
`default_nettype none

module thruster_pulse_controller #(
   parameter int unsigned MAGNITUDE_LEVELS   = 16,
   parameter int unsigned FUEL_FRACTION_BITS = 24
) (
   input  wire logic        clock,
   input  wire logic        reset,
   tpc_stream_if.sink       req_if,
   tpc_stream_if.source     rsp_if,
   tpc_stream_if.sink       csr_if
);

   localparam int unsigned ML_W   = $clog2(MAGNITUDE_LEVELS + 1);
   localparam int unsigned LHS_W  = tpc_pkg::TPS_W + ML_W;
   localparam int unsigned RHS_W  = tpc_pkg::MAG_W + tpc_pkg::TPS_W;
   localparam int unsigned CMP_W  = (LHS_W > RHS_W) ? LHS_W : RHS_W;
   localparam int unsigned FUEL_W = FUEL_FRACTION_BITS + tpc_pkg::PCT_W;
   localparam int unsigned SUB_W  = (FUEL_W > tpc_pkg::FPT_W) ? FUEL_W : tpc_pkg::FPT_W;
   localparam logic [FUEL_W-1:0] FUEL_RESET =
      FUEL_W'(100) << FUEL_FRACTION_BITS;

   // config
   logic [tpc_pkg::TPS_W-1:0]  tps_ff;
   logic [tpc_pkg::FPT_W-1:0]  fpt_ff;

   // pipeline
   logic                       s1_valid_ff;
   tpc_pkg::req_payload_type   s1_ff;
   logic                       out_valid_ff;
   tpc_pkg::rsp_payload_type   out_ff;
   tpc_pkg::rsp_payload_type   out_in;
   logic                       s1_adv;

   // tick state
   logic [tpc_pkg::SEL_W-1:0]  sel_ff,     sel_in;
   logic [tpc_pkg::MAG_W-1:0]  mag_ff,     mag_in;
   logic [tpc_pkg::DUR_W-1:0]  dur_ff,     dur_in;
   logic [tpc_pkg::DUR_W-1:0]  elapsed_ff, elapsed_in;
   logic [tpc_pkg::TPS_W-1:0]  sub_ff,     sub_in;
   logic [tpc_pkg::SEL_W-1:0]  drive_ff,   drive_in;
   logic                       last_ff,    last_in;
   logic [FUEL_W-1:0]          fuel_ff,    fuel_in;

   // combinational helpers
   logic [tpc_pkg::DUR_W-1:0]  elapsed_cur;
   logic [tpc_pkg::TPS_W-1:0]  sub_cur;
   logic                       active;
   logic                       pulse;
   logic [CMP_W-1:0]           lhs;
   logic [CMP_W-1:0]           rhs;
   logic [tpc_pkg::TPS_W-1:0]  sub_inc;
   logic [SUB_W-1:0]           fuel_ext;
   logic [SUB_W-1:0]           fpt_ext;
   logic [tpc_pkg::PCT_W-1:0]  pct;

   assign s1_adv       = s1_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready = !s1_valid_ff || s1_adv;
   assign rsp_if.valid = out_valid_ff;
   assign rsp_if.payload = out_ff;
   assign csr_if.ready = 1'b1;

   always_comb begin
      sel_in     = sel_ff;
      mag_in     = mag_ff;
      dur_in     = dur_ff;
      elapsed_cur = elapsed_ff;
      sub_cur    = sub_ff;
      if (s1_ff.command_valid) begin
         sel_in      = s1_ff.command_word[3:0];
         mag_in      = s1_ff.command_word[7:4];
         dur_in      = s1_ff.command_word[15:8];
         elapsed_cur = '0;
         sub_cur     = '0;
      end

      active = elapsed_cur < dur_in;
      lhs    = CMP_W'(sub_cur) * CMP_W'(MAGNITUDE_LEVELS);
      rhs    = CMP_W'(mag_in) * CMP_W'(tps_ff);
      pulse  = active && (lhs < rhs);

      elapsed_in = elapsed_cur;
      sub_in     = sub_cur;
      sub_inc    = sub_cur + tpc_pkg::TPS_W'(1);
      if (!active) begin
         drive_in = '0;
      end else begin
         drive_in = pulse ? (drive_ff | sel_in) : (drive_ff & ~sel_in);
         if (sub_inc >= tps_ff) begin
            sub_in = '0;
            if (elapsed_cur != tpc_pkg::ELAPSED_MAX) begin
               elapsed_in = elapsed_cur + tpc_pkg::DUR_W'(1);
            end
         end else begin
            sub_in = sub_inc;
         end
      end

      fuel_ext = SUB_W'(fuel_ff);
      fpt_ext  = SUB_W'(fpt_ff);
      fuel_in  = fuel_ff;
      // burn only on the second and later consecutive on ticks
      if (pulse && last_ff) begin
         fuel_in = (fuel_ext > fpt_ext) ? FUEL_W'(fuel_ext - fpt_ext) : '0;
      end
      last_in = pulse;

      pct = fuel_in[FUEL_W-1 -: tpc_pkg::PCT_W];
      if (pct > tpc_pkg::FUEL_FULL_PCT) begin
         pct = tpc_pkg::FUEL_FULL_PCT;
      end

      out_in.drive_down     = drive_in[0];
      out_in.drive_up       = drive_in[1];
      out_in.drive_right    = drive_in[2];
      out_in.drive_left     = drive_in[3];
      out_in.impulse_on     = pulse;
      out_in.command_active = active;
      out_in.fuel_percent   = pct;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff <= tpc_pkg::TPS_RESET;
         fpt_ff <= tpc_pkg::FPT_RESET;
      end else if (csr_if.valid) begin
         if (csr_if.payload.index == tpc_pkg::REG_TICKS_PER_SECOND) begin
            tps_ff <= csr_if.payload.data[tpc_pkg::TPS_W-1:0];
         end else if (csr_if.payload.index == tpc_pkg::REG_FUEL_PER_TICK) begin
            fpt_ff <= csr_if.payload.data[tpc_pkg::FPT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         sel_ff       <= '0;
         mag_ff       <= '0;
         dur_ff       <= '0;
         elapsed_ff   <= '0;
         sub_ff       <= '0;
         drive_ff     <= '0;
         last_ff      <= 1'b0;
         fuel_ff      <= FUEL_RESET;
      end else begin
         if (req_if.ready) begin
            s1_valid_ff <= req_if.valid;
         end
         if (s1_adv) begin
            out_valid_ff <= 1'b1;
            sel_ff       <= sel_in;
            mag_ff       <= mag_in;
            dur_ff       <= dur_in;
            elapsed_ff   <= elapsed_in;
            sub_ff       <= sub_in;
            drive_ff     <= drive_in;
            last_ff      <= last_in;
            fuel_ff      <= fuel_in;
         end else if (rsp_if.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         s1_ff <= req_if.payload;
      end
      if (s1_adv) begin
         out_ff <= out_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/tpc_checker.sv @@
`default_nettype none

module tpc_checker (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_ready,
   input wire tpc_pkg::rsp_payload_type rsp_payload
);

   logic [3:0] drives;
   assign drives = {rsp_payload.drive_left, rsp_payload.drive_right,
                    rsp_payload.drive_up, rsp_payload.drive_down};

   a_idle_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before transfer");

   a_impulse_needs_active: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.impulse_on |-> rsp_payload.command_active)
      else $error("impulse on with inactive command");

   a_inactive_drives_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.command_active |-> drives == 4'b0000)
      else $error("drive on with inactive command");

   a_fuel_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.fuel_percent <= tpc_pkg::FUEL_FULL_PCT)
      else $error("fuel readout above full");

endmodule

bind thruster_pulse_controller tpc_checker u_tpc_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_payload (rsp_if.payload)
);

`default_nettype wire

@@ sim/thruster_pulse_controller_test.sv @@
`timescale 1ns / 1ps

module thruster_pulse_controller_test;

   localparam int unsigned MAG_LEVELS     = 16;
   localparam int unsigned FUEL_FRAC      = 24;
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned RANDOM_TICKS   = 160;
   localparam int unsigned DRAIN_TICKS    = 279;
   localparam int unsigned SETTING_COUNT  = 8;
   localparam int unsigned DIRECTED_COUNT = 20;

   // no register decodes here; writes to it must change nothing
   localparam logic [tpc_pkg::CSR_INDEX_W-1:0] REG_UNUSED = '1;

   localparam tpc_pkg::rsp_payload_type IDLE_RSP    =
      {4'b0000, 1'b0, 1'b0, tpc_pkg::FUEL_FULL_PCT};
   localparam tpc_pkg::rsp_payload_type FULL_ON_RSP =
      {4'b1111, 1'b1, 1'b1, tpc_pkg::FUEL_FULL_PCT};
   localparam tpc_pkg::rsp_payload_type PREDICTED   = '0;

   typedef struct packed {
      logic                     is_typed;
      tpc_pkg::req_payload_type req;
      tpc_pkg::rsp_payload_type rsp;
   } directed_row_type;

   typedef struct packed {
      logic [tpc_pkg::TPS_W-1:0] tps;
      logic [tpc_pkg::FPT_W-1:0] fpt;
      logic                      gaps;
   } setting_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tpc_stream_if #(.payload_type(tpc_pkg::req_payload_type)) req_if ();
   tpc_stream_if #(.payload_type(tpc_pkg::rsp_payload_type)) rsp_if ();
   tpc_stream_if #(.payload_type(tpc_pkg::csr_payload_type)) csr_if ();

   thruster_pulse_controller i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // controller state as seen after each tick
   logic [tpc_pkg::TPS_W-1:0] cfg_ticks_per_second = tpc_pkg::TPS_RESET;
   logic [tpc_pkg::FPT_W-1:0] cfg_fuel_per_tick    = tpc_pkg::FPT_RESET;
   logic [tpc_pkg::SEL_W-1:0] cmd_select           = '0;
   logic [tpc_pkg::MAG_W-1:0] cmd_magnitude        = '0;
   logic [tpc_pkg::DUR_W-1:0] cmd_duration         = '0;
   logic [tpc_pkg::DUR_W-1:0] seconds_elapsed      = '0;
   logic [tpc_pkg::TPS_W-1:0] tick_in_second       = '0;
   logic [tpc_pkg::SEL_W-1:0] drive_state          = '0;
   logic                      pulse_prev           = 1'b0;
   logic [30:0]               fuel_fixed           = 31'(100) << FUEL_FRAC;

   tpc_pkg::rsp_payload_type pending_rsp[$];
   int unsigned     error_count    = 0;
   int unsigned     checked_count  = 0;
   int unsigned     tick_count     = 0;
   int unsigned     command_count  = 0;
   int unsigned     register_count = 0;
   int unsigned     quiet_cycles   = 0;
   logic            gaps_on        = 1'b1;

   directed_row_type directed_rows [DIRECTED_COUNT] = '{
      {1'b1, 1'b0, 16'h0000, IDLE_RSP},
      {1'b1, 1'b0, 16'hFFFF, IDLE_RSP},
      {1'b1, 1'b1, 16'h0000, IDLE_RSP},
      {1'b1, 1'b1, 16'h00FF, IDLE_RSP},
      {1'b1, 1'b1, 16'hFFFF, FULL_ON_RSP},
      {1'b0, 1'b0, 16'h0000, PREDICTED},
      {1'b0, 1'b1, 16'h0105, PREDICTED},
      {1'b0, 1'b1, 16'h01F2, PREDICTED},
      {1'b0, 1'b1, 16'h0180, PREDICTED},
      {1'b0, 1'b1, 16'h0118, PREDICTED},
      {1'b0, 1'b0, 16'h0000, PREDICTED},
      {1'b0, 1'b0, 16'h0000, PREDICTED},
      {1'b0, 1'b0, 16'h0000, PREDICTED},
      {1'b0, 1'b0, 16'h0000, PREDICTED},
      {1'b0, 1'b0, 16'h0000, PREDICTED},
      {1'b0, 1'b0, 16'h0000, PREDICTED},
      {1'b0, 1'b0, 16'h0000, PREDICTED},
      {1'b0, 1'b0, 16'h0000, PREDICTED},
      {1'b0, 1'b1, 16'h01F4, PREDICTED},
      {1'b0, 1'b1, 16'h0000, PREDICTED}
   };

   // entry 6 gets random values at run time
   setting_type phase_settings [SETTING_COUNT] = '{
      {10'd1,    16'd0,     1'b1},
      {10'd1000, 16'd65535, 1'b0},
      {10'd0,    16'd37,    1'b1},
      {10'd1023, 16'd1,     1'b1},
      {10'd5,    16'd21,    1'b0},
      {10'd2,    16'd4096,  1'b1},
      {10'd9,    16'd300,   1'b1},
      {10'd3,    16'd21,    1'b0}
   };

   function automatic tpc_pkg::rsp_payload_type advance_tick(
      input tpc_pkg::req_payload_type r);
      tpc_pkg::rsp_payload_type  result;
      logic                      active;
      logic                      pulse;
      logic [tpc_pkg::TPS_W-1:0] next_tick;
      logic [30:0]               fuel_pct;
      pulse = 1'b0;
      if (r.command_valid) begin
         cmd_select      = r.command_word[3:0];
         cmd_magnitude   = r.command_word[7:4];
         cmd_duration    = r.command_word[15:8];
         seconds_elapsed = '0;
         tick_in_second  = '0;
      end
      active = seconds_elapsed < cmd_duration;
      if (!active) begin
         drive_state = '0;
      end else begin
         pulse = (32'(tick_in_second) * MAG_LEVELS) <
                 (32'(cmd_magnitude) * 32'(cfg_ticks_per_second));
         if (pulse)
            drive_state = drive_state | cmd_select;
         else
            drive_state = drive_state & ~cmd_select;
         next_tick = tick_in_second + 10'd1;
         if (next_tick >= cfg_ticks_per_second) begin
            tick_in_second = '0;
            if (seconds_elapsed != tpc_pkg::ELAPSED_MAX)
               seconds_elapsed = seconds_elapsed + 8'd1;
         end else begin
            tick_in_second = next_tick;
         end
      end
      // only back-to-back on ticks burn fuel
      if (pulse && pulse_prev)
         fuel_fixed = (fuel_fixed > 31'(cfg_fuel_per_tick)) ?
                      fuel_fixed - 31'(cfg_fuel_per_tick) : '0;
      pulse_prev = pulse;
      fuel_pct = fuel_fixed >> FUEL_FRAC;
      result.drive_down     = drive_state[0];
      result.drive_up       = drive_state[1];
      result.drive_right    = drive_state[2];
      result.drive_left     = drive_state[3];
      result.impulse_on     = pulse;
      result.command_active = active;
      result.fuel_percent   = (fuel_pct > 31'(tpc_pkg::FUEL_FULL_PCT)) ?
                              tpc_pkg::FUEL_FULL_PCT : fuel_pct[6:0];
      return result;
   endfunction

   function automatic tpc_pkg::req_payload_type random_tick();
      tpc_pkg::req_payload_type r;
      r.command_valid = ($urandom_range(0, 9) == 0);
      r.command_word  = 16'($urandom);
      // mostly short durations so commands run out and get replaced
      if (r.command_valid && $urandom_range(0, 9) < 7)
         r.command_word[15:8] = 8'($urandom_range(0, 3));
      return r;
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endfunction

   task automatic send_tick(input tpc_pkg::req_payload_type r, input logic is_typed,
                            input tpc_pkg::rsp_payload_type typed_rsp);
      tpc_pkg::rsp_payload_type predicted;
      if (gaps_on && $urandom_range(0, 9) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= r;
      do @(posedge clock); while (!req_if.ready);
      predicted = advance_tick(r);
      pending_rsp.push_back(is_typed ? typed_rsp : predicted);
      tick_count++;
      if (r.command_valid)
         command_count++;
   endtask

   // register writes only once every response is back
   task automatic write_register(input logic [tpc_pkg::CSR_INDEX_W-1:0] index,
                                 input logic [tpc_pkg::CSR_DATA_W-1:0] data);
      req_if.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_if.valid   <= 1'b1;
      csr_if.payload <= {index, data};
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      register_count++;
      case (index)
         tpc_pkg::REG_TICKS_PER_SECOND: cfg_ticks_per_second = data[tpc_pkg::TPS_W-1:0];
         tpc_pkg::REG_FUEL_PER_TICK:    cfg_fuel_per_tick = data;
         default: ;
      endcase
   endtask

   // response side stalls in bursts
   initial begin
      int unsigned stall_left;
      stall_left = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left == 0 && gaps_on && $urandom_range(0, 9) == 0)
            stall_left = $urandom_range(1, 17);
         if (stall_left != 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      tpc_pkg::rsp_payload_type want;
      tpc_pkg::rsp_payload_type got;
      if (!reset) begin
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
             (csr_if.valid && csr_if.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("FAILURE");
            $finish;
         end else if (rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.payload;
            if (pending_rsp.size() == 0) begin
               $display("%0t: response with none pending, expected nothing, actual %h",
                        $time, got);
               error_count++;
            end else begin
               want = pending_rsp.pop_front();
               check_field("drive_down", want.drive_down, got.drive_down);
               check_field("drive_up", want.drive_up, got.drive_up);
               check_field("drive_right", want.drive_right, got.drive_right);
               check_field("drive_left", want.drive_left, got.drive_left);
               check_field("impulse_on", want.impulse_on, got.impulse_on);
               check_field("command_active", want.command_active, got.command_active);
               check_field("fuel_percent", want.fuel_percent, got.fuel_percent);
               checked_count++;
            end
         end
      end
   end

   initial begin
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      csr_if.valid   = 1'b0;
      csr_if.payload = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed ticks under the reset register values
      for (int i = 0; i < DIRECTED_COUNT; i++)
         send_tick(directed_rows[i].req, directed_rows[i].is_typed, directed_rows[i].rsp);

      phase_settings[6].tps = 10'($urandom_range(1, 60));
      phase_settings[6].fpt = 16'($urandom);
      for (int p = 0; p < SETTING_COUNT; p++) begin
         gaps_on = phase_settings[p].gaps;
         write_register(tpc_pkg::REG_TICKS_PER_SECOND,
                        tpc_pkg::CSR_DATA_W'(phase_settings[p].tps));
         write_register(tpc_pkg::REG_FUEL_PER_TICK, phase_settings[p].fpt);
         if (p == 3)
            write_register(REG_UNUSED, '1);
         repeat (RANDOM_TICKS) send_tick(random_tick(), 1'b0, PREDICTED);
      end

      // full-thrust command at the highest burn rate, held past its duration
      gaps_on = 1'b0;
      write_register(tpc_pkg::REG_TICKS_PER_SECOND, tpc_pkg::CSR_DATA_W'(1));
      write_register(tpc_pkg::REG_FUEL_PER_TICK, '1);
      send_tick({1'b1, 8'hFF, 4'hF, 4'($urandom_range(0, 15))}, 1'b0, PREDICTED);
      repeat (DRAIN_TICKS) send_tick({1'b0, 16'($urandom)}, 1'b0, PREDICTED);

      req_if.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("Checked %0d responses over %0d ticks, %0d commands and %0d register writes.",
               checked_count, tick_count, command_count, register_count);
      $display("Fuel model ended at %0d percent.", fuel_fixed >> FUEL_FRAC);
      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/tpc_pkg.sv
rtl/tpc_stream_if.sv
rtl/thruster_pulse_controller.sv
rtl/tpc_checker.sv
sim/thruster_pulse_controller_test.sv
